>>> rtl/core/i2cee_pkg.sv
package i2cee_pkg;

   localparam int WRITE_STEPS = 89;
   localparam int READ_STEPS  = 108;
   localparam int STEP_W      = $clog2(READ_STEPS);

   localparam logic [6:0] DEVICE_SELECT_RESET = 7'd80;

   localparam int QUEUE_DEPTH_DEFAULT  = 2;
   localparam int RESULT_DEPTH_DEFAULT = 2;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] word_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       write_protect;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  word_address;
      logic [7:0]  write_data;
      logic        sda_in;
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_READ  = 3'b100
   } seq_state_type;

endpackage

>>> rtl/core/i2cee_fifo.sv
module i2cee_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/i2cee_front.sv
module i2cee_front
   import i2cee_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req,
   output logic    full,
   output op_type  op,
   output logic    op_valid,
   input  logic    op_pop
);

   op_type classified;
   logic   queue_empty;
   logic [$bits(op_type)-1:0] queue_out;

   always_comb begin
      classified.word_address = req.word_address;
      classified.write_data   = req.write_data;
      classified.sda_in       = req.sda_in;
      case (req.mode)
         MODE_TICK:  classified.kind = OP_TICK;
         MODE_READ:  classified.kind = OP_READ;
         MODE_WRITE: classified.kind = OP_WRITE;
         default:    classified.kind = OP_NONE;
      endcase
   end

   i2cee_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(op_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (classified),
      .full      (full),
      .pop       (op_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   assign op       = queue_out;
   assign op_valid = !queue_empty;

endmodule

>>> rtl/core/i2cee_back.sv
module i2cee_back
   import i2cee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] device_select,
   input  op_type     op,
   input  logic       op_valid,
   output logic       op_pop,
   input  logic       res_full,
   output logic       res_push,
   output rsp_type    res
);

   localparam logic [STEP_W-1:0] W_WP_LOW  = STEP_W'(0);
   localparam logic [STEP_W-1:0] W_IDLE_HI = STEP_W'(1);
   localparam logic [STEP_W-1:0] W_SCL_LOW = STEP_W'(2);
   localparam logic [STEP_W-1:0] W_START   = STEP_W'(3);
   localparam logic [STEP_W-1:0] W_SEL     = STEP_W'(7);
   localparam logic [STEP_W-1:0] W_ADDR    = STEP_W'(33);
   localparam logic [STEP_W-1:0] W_DATA    = STEP_W'(59);
   localparam logic [STEP_W-1:0] W_STOP    = STEP_W'(85);
   localparam logic [STEP_W-1:0] W_STOP_CK = STEP_W'(86);
   localparam logic [STEP_W-1:0] W_STOP_HI = STEP_W'(87);
   localparam logic [STEP_W-1:0] W_LAST    = STEP_W'(WRITE_STEPS - 1);

   localparam logic [STEP_W-1:0] R_IDLE_HI = STEP_W'(0);
   localparam logic [STEP_W-1:0] R_SCL_LOW = STEP_W'(1);
   localparam logic [STEP_W-1:0] R_START   = STEP_W'(2);
   localparam logic [STEP_W-1:0] R_SEL     = STEP_W'(6);
   localparam logic [STEP_W-1:0] R_ADDR    = STEP_W'(32);
   localparam logic [STEP_W-1:0] R_RESTART = STEP_W'(58);
   localparam logic [STEP_W-1:0] R_SEL_RD  = STEP_W'(62);
   localparam logic [STEP_W-1:0] R_RELEASE = STEP_W'(88);
   localparam logic [STEP_W-1:0] R_BITS    = STEP_W'(89);
   localparam logic [STEP_W-1:0] R_STOP    = STEP_W'(105);
   localparam logic [STEP_W-1:0] R_STOP_CK = STEP_W'(106);
   localparam logic [STEP_W-1:0] R_LAST    = STEP_W'(READ_STEPS - 1);

   localparam logic [4:0] BYTE_BIT_STEPS = 5'd24;
   localparam logic [4:0] BYTE_ACK_HIGH  = 5'd24;
   localparam logic [1:0] PH_DATA = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_FALL = 2'd2;
   localparam logic [3:0] LAST_READ_BIT = 4'd15;

   seq_state_type     st_ff, st_in;
   logic [STEP_W-1:0] k_ff, k_in;
   logic [1:0]        ph_ff, ph_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        addr_ff, addr_in;
   logic [7:0]        data_ff, data_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              wp_ff, wp_in;
   logic [7:0]        last_read_ff, last_read_in;
   logic              done;
   logic              fire;

   logic [7:0]        sel;
   logic              seg_start, seg_byte;
   logic [STEP_W-1:0] start_base, byte_base;
   logic [STEP_W-1:0] start_diff, byte_diff, bit_diff;
   logic [1:0]        start_off;
   logic [4:0]        byte_off;
   logic [3:0]        bit_j;
   logic [7:0]        byte_val;
   logic [7:0]        shift_cur;

   assign fire     = op_valid && !res_full;
   assign op_pop   = fire;
   assign res_push = fire;
   assign sel      = {device_select, 1'b0};

   // locate the step within a start condition or a byte
   always_comb begin
      seg_start  = 1'b0;
      seg_byte   = 1'b0;
      start_base = W_START;
      byte_base  = W_SEL;
      byte_val   = sel;
      if (st_ff == ST_WRITE) begin
         if (k_ff >= W_START && k_ff < W_SEL) begin
            seg_start = 1'b1;
         end else if (k_ff >= W_SEL && k_ff < W_ADDR) begin
            seg_byte = 1'b1;
         end else if (k_ff >= W_ADDR && k_ff < W_DATA) begin
            seg_byte  = 1'b1;
            byte_base = W_ADDR;
            byte_val  = addr_ff;
         end else if (k_ff >= W_DATA && k_ff < W_STOP) begin
            seg_byte  = 1'b1;
            byte_base = W_DATA;
            byte_val  = data_ff;
         end
      end else begin
         if (k_ff >= R_START && k_ff < R_SEL) begin
            seg_start  = 1'b1;
            start_base = R_START;
         end else if (k_ff >= R_SEL && k_ff < R_ADDR) begin
            seg_byte  = 1'b1;
            byte_base = R_SEL;
         end else if (k_ff >= R_ADDR && k_ff < R_RESTART) begin
            seg_byte  = 1'b1;
            byte_base = R_ADDR;
            byte_val  = addr_ff;
         end else if (k_ff >= R_RESTART && k_ff < R_SEL_RD) begin
            seg_start  = 1'b1;
            start_base = R_RESTART;
         end else if (k_ff >= R_SEL_RD && k_ff < R_RELEASE) begin
            seg_byte  = 1'b1;
            byte_base = R_SEL_RD;
            byte_val  = sel | 8'h01;
         end
      end
      start_diff = k_ff - start_base;
      byte_diff  = k_ff - byte_base;
      bit_diff   = k_ff - R_BITS;
      start_off  = start_diff[1:0];
      byte_off   = byte_diff[4:0];
      bit_j      = bit_diff[3:0];
   end

   always_comb begin
      st_in        = st_ff;
      k_in         = k_ff;
      ph_in        = ph_ff;
      shift_in     = shift_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      wp_in        = wp_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      shift_cur    = (byte_off == '0) ? byte_val : shift_ff;

      if (st_ff == ST_IDLE) begin
         if (op.kind == OP_READ || op.kind == OP_WRITE) begin
            st_in   = (op.kind == OP_WRITE) ? ST_WRITE : ST_READ;
            addr_in = op.word_address;
            data_in = op.write_data;
            k_in    = '0;
            ph_in   = PH_DATA;
         end
      end else if (op.kind == OP_TICK) begin
         ph_in = PH_DATA;
         if (seg_start) begin
            case (start_off)
               2'd0:    sda_in = 1'b1;
               2'd1:    scl_in = 1'b1;
               2'd2:    sda_in = 1'b0;
               default: scl_in = 1'b0;
            endcase
         end else if (seg_byte) begin
            if (byte_off < BYTE_BIT_STEPS) begin
               if (ph_ff != PH_FALL) begin
                  ph_in = ph_ff + 2'd1;
               end
               case (ph_ff)
                  PH_DATA: begin
                     shift_in = shift_cur;
                     sda_in   = shift_cur[7];
                  end
                  PH_RISE: scl_in = 1'b1;
                  default: begin
                     scl_in   = 1'b0;
                     shift_in = {shift_ff[6:0], 1'b0};
                  end
               endcase
            end else if (byte_off == BYTE_ACK_HIGH) begin
               scl_in = 1'b1;
            end else begin
               scl_in = 1'b0;
            end
         end else if (st_ff == ST_WRITE) begin
            case (k_ff)
               W_WP_LOW:  wp_in  = 1'b0;
               W_IDLE_HI: sda_in = 1'b1;
               W_SCL_LOW: scl_in = 1'b0;
               W_STOP:    sda_in = 1'b0;
               W_STOP_CK: scl_in = 1'b1;
               W_STOP_HI: sda_in = 1'b1;
               default:   wp_in  = 1'b1;
            endcase
         end else begin
            if (k_ff == R_IDLE_HI || k_ff == R_RELEASE) begin
               sda_in = 1'b1;
            end else if (k_ff == R_SCL_LOW) begin
               scl_in = 1'b0;
            end else if (k_ff >= R_BITS && k_ff < R_STOP) begin
               if (!bit_j[0]) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  scl_in   = 1'b1;
               end else begin
                  // sample while the clock has been high
                  shift_in = {shift_ff[7:1], op.sda_in};
                  scl_in   = 1'b0;
                  if (bit_j == LAST_READ_BIT) begin
                     last_read_in = {shift_ff[7:1], op.sda_in};
                  end
               end
            end else if (k_ff == R_STOP) begin
               sda_in = 1'b0;
            end else if (k_ff == R_STOP_CK) begin
               scl_in = 1'b1;
            end else begin
               sda_in = 1'b1;
            end
         end
         if ((st_ff == ST_WRITE && k_ff == W_LAST) || (st_ff == ST_READ && k_ff == R_LAST)) begin
            st_in = ST_IDLE;
            k_in  = '0;
            done  = 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_comb begin
      res.scl_out       = scl_in;
      res.sda_out       = sda_in;
      res.write_protect = wp_in;
      res.busy_res      = (st_in != ST_IDLE);
      res.done_res      = done;
      res.read_data     = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         k_ff         <= '0;
         ph_ff        <= PH_DATA;
         shift_ff     <= '0;
         addr_ff      <= '0;
         data_ff      <= '0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b1;
         wp_ff        <= 1'b1;
         last_read_ff <= '0;
      end else if (fire) begin
         st_ff        <= st_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         wp_ff        <= wp_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

>>> rtl/core/i2c_eeprom_byte_access_master.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------
// request   | in        | push / full          | req_data (req_type)
// response  | out       | empty / pop          | rsp_data (rsp_type)
// csr       | in        | csr_valid/csr_ready  | csr_data (device select)
//
// one item per clock sustained while the response queue has room; every item gives one
// response beat: the item is registered in the command queue, then the sequencer step,
// one pin change per tick, pushes its beat into the response queue.
// synchronous reset empties both queues, idles the sequencer, device select 80.
// with pop low the response queue fills, then the command queue, then full rises.
module i2c_eeprom_byte_access_master
   import i2cee_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  req_type    req_data,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   logic [6:0] device_select_ff, device_select_in;
   op_type     op;
   logic       op_valid, op_pop;
   logic       res_full, res_push;
   rsp_type    res;
   logic [$bits(rsp_type)-1:0] res_out;

   assign csr_ready        = 1'b1;
   assign device_select_in = (csr_valid && csr_ready) ? csr_data : device_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_select_ff <= DEVICE_SELECT_RESET;
      end else begin
         device_select_ff <= device_select_in;
      end
   end

   i2cee_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req      (req_data),
      .full     (full),
      .op       (op),
      .op_valid (op_valid),
      .op_pop   (op_pop)
   );

   i2cee_back u_back (
      .clock         (clock),
      .reset         (reset),
      .device_select (device_select_ff),
      .op            (op),
      .op_valid      (op_valid),
      .op_pop        (op_pop),
      .res_full      (res_full),
      .res_push      (res_push),
      .res           (res)
   );

   i2cee_fifo #(
      .DEPTH (RESULT_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_out),
      .empty     (empty)
   );

   assign rsp_data = res_out;

`ifndef SYNTHESIS
   // sequencer only steps when the response queue has room
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("response pushed into full queue");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.done_res) |-> !res.busy_res)
      else $error("done beat still busy");

   // idle bus always has data released and write protect high
   a_idle_levels: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res.busy_res) |-> (res.sda_out && res.write_protect))
      else $error("idle pin levels wrong");

   a_pop_follows_push: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> res_push)
      else $error("command consumed without response");
`endif

endmodule

>>> test/tb_i2c_eeprom_byte_access_master.sv
`timescale 1ns / 100ps

module tb_i2c_eeprom_byte_access_master;
   import i2cee_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 400;

   class eeprom_pin_tracker;
      logic [6:0] dev_sel    = DEVICE_SELECT_RESET;
      logic [7:0] step_no    = '0;
      logic [7:0] shifter    = '0;
      logic       write_op   = 1'b0;
      logic [7:0] addr_latch = '0;
      logic [7:0] data_latch = '0;
      logic       scl        = 1'b0;
      logic       sda        = 1'b1;
      logic       wp         = 1'b1;
      logic [7:0] read_byte  = '0;
      int         mismatches = 0;
      rsp_type    pins_due[$];

      function void start_phase(int o);
         case (o)
            0: sda = 1'b1;
            1: scl = 1'b1;
            2: sda = 1'b0;
            default: scl = 1'b0;
         endcase
      endfunction

      // eight data bits of three steps each, then the unchecked ack clock
      function void byte_phase(int o, logic [7:0] value);
         if (o < 24) begin
            case (o % 3)
               0: begin
                  if (o == 0) shifter = value;
                  sda = shifter[7];
               end
               1: scl = 1'b1;
               default: begin
                  scl = 1'b0;
                  shifter = shifter << 1;
               end
            endcase
         end else begin
            scl = (o == 24);
         end
      endfunction

      function void write_step(int k);
         logic [7:0] sel;
         sel = {dev_sel, 1'b0};
         if (k == 0) wp = 1'b0;
         else if (k == 1) sda = 1'b1;
         else if (k == 2) scl = 1'b0;
         else if (k < 7) start_phase(k - 3);
         else if (k < 33) byte_phase(k - 7, sel);
         else if (k < 59) byte_phase(k - 33, addr_latch);
         else if (k < 85) byte_phase(k - 59, data_latch);
         else if (k == 85) sda = 1'b0;
         else if (k == 86) scl = 1'b1;
         else if (k == 87) sda = 1'b1;
         else wp = 1'b1;
      endfunction

      function void read_step(int k, logic sda_bit);
         logic [7:0] sel;
         int         j;
         sel = {dev_sel, 1'b0};
         j = k - 89;
         if (k == 0) sda = 1'b1;
         else if (k == 1) scl = 1'b0;
         else if (k < 6) start_phase(k - 2);
         else if (k < 32) byte_phase(k - 6, sel);
         else if (k < 58) byte_phase(k - 32, addr_latch);
         else if (k < 62) start_phase(k - 58);
         else if (k < 88) byte_phase(k - 62, sel | 8'h01);
         else if (k == 88) sda = 1'b1;
         else if (k < 105) begin
            // sample on the falling scl step, after scl was high
            if (j % 2 == 0) begin
               shifter = shifter << 1;
               scl = 1'b1;
            end else begin
               shifter[0] = sda_bit;
               scl = 1'b0;
               if (j == 15) read_byte = shifter;
            end
         end
         else if (k == 105) sda = 1'b0;
         else if (k == 106) scl = 1'b1;
         else sda = 1'b1;
      endfunction

      function void take_request(req_type item);
         rsp_type want;
         int      k;
         logic    finished;
         finished = 1'b0;
         if (step_no == 0) begin
            if (item.mode == OP_READ || item.mode == OP_WRITE) begin
               write_op   = (item.mode == OP_WRITE);
               addr_latch = item.word_address;
               data_latch = item.write_data;
               step_no    = 8'd1;
            end
         end else if (item.mode == OP_TICK) begin
            k = step_no - 1;
            if (write_op) write_step(k);
            else read_step(k, item.sda_in);
            if (k + 1 >= (write_op ? WRITE_STEPS : READ_STEPS)) begin
               step_no  = '0;
               finished = 1'b1;
            end else begin
               step_no = 8'(k + 2);
            end
         end
         want.scl_out       = scl;
         want.sda_out       = sda;
         want.write_protect = wp;
         want.busy_res      = (step_no != 0);
         want.done_res      = finished;
         want.read_data     = read_byte;
         pins_due.push_back(want);
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         if (pins_due.size() == 0) begin
            $display("%0t: response beat with nothing pending, expected none actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pins_due.pop_front();
         if (got !== want) begin
            $display("%0t: response mismatch, expected %h actual %h", $time, want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       push      = 1'b0;
   req_type    req_data  = '0;
   logic       full;
   logic       empty;
   logic       pop       = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data  = '0;

   eeprom_pin_tracker tracker = new();
   bit steady         = 1'b0;
   int stall_cycles   = 0;
   int sequence_items = 0;
   int transfers      = 0;
   int pick;

   i2c_eeprom_byte_access_master uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      pop <= !reset && (steady || $urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) tracker.match_response(rsp_data);
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("i2c_eeprom_byte_access_master regression: fail");
      $finish;
   end

   function automatic req_type random_request(op_kind_type op);
      req_type item;
      item.mode         = op;
      item.word_address = 8'($urandom);
      item.write_data   = 8'($urandom);
      item.sda_in       = 1'($urandom);
      return item;
   endfunction

   // entered and left just after a falling edge
   task automatic send_item(input req_type item);
      while (!steady && $urandom_range(99) < 31) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full) @(posedge clock);
      tracker.take_request(item);
      @(negedge clock);
   endtask

   task automatic drain;
      push <= 1'b0;
      while (tracker.pins_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_device_select(input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.dev_sel = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one command, then ticks until the sequence ends; noise_pct of the beats
   // are commands or no-ops sent while busy
   task automatic run_transfer(input logic is_write, input logic [7:0] addr,
                               input logic [7:0] data, input logic [7:0] sda_pattern,
                               input int noise_pct);
      req_type item;
      int      k;
      int      j;
      item = random_request(is_write ? OP_WRITE : OP_READ);
      item.word_address = addr;
      item.write_data   = data;
      send_item(item);
      sequence_items++;
      while (tracker.step_no != 0) begin
         if ($urandom_range(99) < noise_pct) begin
            item = random_request(op_kind_type'($urandom_range(1, 3)));
         end else begin
            item = random_request(OP_TICK);
            k = tracker.step_no - 1;
            j = k - 89;
            if (!tracker.write_op && k >= 89 && k < 105 && j % 2 == 1)
               item.sda_in = sda_pattern[7 - j / 2];
            sequence_items++;
         end
         send_item(item);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle tick and no-op, then transfers at the field extremes
      send_item(random_request(OP_TICK));
      send_item(random_request(OP_NONE));
      run_transfer(1'b1, 8'hff, 8'h00, 8'h00, 20);
      drain;
      write_device_select(7'd0);
      run_transfer(1'b0, 8'h00, 8'hff, 8'hff, 20);
      drain;
      write_device_select(7'd127);

      while (sequence_items < RANDOM_ITEMS) begin
         if (transfers % 3 == 2) begin
            drain;
            pick = $urandom_range(3);
            write_device_select(pick == 0 ? 7'd0 : pick == 1 ? 7'd127 : 7'($urandom));
         end
         repeat ($urandom_range(3))
            send_item(random_request($urandom_range(1) ? OP_TICK : OP_NONE));
         steady = (transfers == 1);
         run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(1) ? 0 : 12);
         steady = 1'b0;
         transfers++;
      end

      drain;
      repeat (8) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pins_due.size() == 0) begin
         $display("i2c_eeprom_byte_access_master regression: pass");
      end else begin
         $display("i2c_eeprom_byte_access_master regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/i2cee_pkg.sv
rtl/core/i2cee_fifo.sv
rtl/core/i2cee_front.sv
rtl/core/i2cee_back.sv
rtl/core/i2c_eeprom_byte_access_master.sv
test/tb_i2c_eeprom_byte_access_master.sv
